// ----- rtl/core/sdd_pkg.sv -----
// shared types, constants and the arctangent table for the source direction block
// no dependencies
`default_nettype none

package sdd_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int ANG_W      = 25;
  localparam int ATAN_W     = 23;
  localparam int ATAN_LEN   = 24;
  localparam int Q_W        = 8;
  localparam int MUL_W      = 24;
  localparam int SQ_W       = 48;
  localparam int S_CLAMP_W  = 35;
  localparam int T_W        = 49;
  localparam int SCALE_W    = 14;

  localparam logic [SCALE_W-1:0]   DIST_SCALE = 14'd16129;
  localparam logic [S_CLAMP_W-1:0] FAR_SQ     = 35'd17451731025;
  localparam logic [15:0]          DIST_RESET = 16'd400;
  localparam logic [Q_W-1:0]       Q_MIN      = 8'd1;
  localparam logic [Q_W-1:0]       Q_SAT      = 8'd255;

  localparam logic [8:0] BEAR_UP    = 9'd0;
  localparam logic [8:0] BEAR_RIGHT = 9'd90;
  localparam logic [8:0] BEAR_DOWN  = 9'd180;
  localparam logic [8:0] BEAR_LEFT  = 9'd270;
  localparam logic [8:0] BEAR_FULL  = 9'd360;
  localparam logic [8:0] ANG_HALF   = 9'd45;
  localparam logic [8:0] ANG_MAX    = 9'd89;

  typedef struct packed {
    logic signed [15:0] listener_x;
    logic signed [15:0] listener_y;
    logic signed [15:0] source_x;
    logic signed [15:0] source_y;
  } in_beat_t;

  typedef struct packed {
    logic [8:0] bearing_deg;
    logic [7:0] scaled_distance;
  } out_beat_t;

  typedef struct packed {
    logic coincident;
    logic dx_pos;
    logic dy_zero;
    logic dy_pos;
    logic num_zero;
    logic num_eq;
  } flags_t;

  // atan(2^-i) in degrees, 16 fractional bits
  function automatic logic [ATAN_W-1:0] atan_q16(input int unsigned i);
    logic [ATAN_W-1:0] r;
    case (i)
      0:  r = 23'd2949120;
      1:  r = 23'd1740967;
      2:  r = 23'd919879;
      3:  r = 23'd466945;
      4:  r = 23'd234379;
      5:  r = 23'd117304;
      6:  r = 23'd58666;
      7:  r = 23'd29335;
      8:  r = 23'd14668;
      9:  r = 23'd7334;
      10: r = 23'd3667;
      11: r = 23'd1833;
      12: r = 23'd917;
      13: r = 23'd458;
      14: r = 23'd229;
      15: r = 23'd115;
      16: r = 23'd57;
      17: r = 23'd29;
      18: r = 23'd14;
      19: r = 23'd7;
      20: r = 23'd4;
      21: r = 23'd2;
      22: r = 23'd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/sdd_cordic_cell.sv -----
// one vectoring rotation of the arctangent chain, registered
// depends on sdd_pkg
`default_nettype none

module sdd_cordic_cell #(
  parameter int XW  = 35,
  parameter int AW  = 16,
  parameter int IDX = 0
) (
  input  wire logic                        clk_i,
  input  wire logic                        en_i,
  input  wire logic signed [XW-1:0]        x_i,
  input  wire logic signed [XW-1:0]        y_i,
  input  wire logic signed [sdd_pkg::ANG_W-1:0] z_i,
  input  wire sdd_pkg::flags_t             flags_i,
  input  wire logic [AW-1:0]               ax_i,
  input  wire logic [AW-1:0]               ay_i,
  output logic signed [XW-1:0]             x_o,
  output logic signed [XW-1:0]             y_o,
  output logic signed [sdd_pkg::ANG_W-1:0] z_o,
  output sdd_pkg::flags_t                  flags_o,
  output logic [AW-1:0]                    ax_o,
  output logic [AW-1:0]                    ay_o
);

  logic signed [sdd_pkg::ANG_W-1:0] step;
  logic signed [XW-1:0]             x_d, y_d;
  logic signed [sdd_pkg::ANG_W-1:0] z_d;

  assign step = sdd_pkg::ANG_W'(sdd_pkg::atan_q16(IDX));

  always_comb begin
    if (y_i > 0) begin
      x_d = x_i + (y_i >>> IDX);
      y_d = y_i - (x_i >>> IDX);
      z_d = z_i + step;
    end else begin
      x_d = x_i - (y_i >>> IDX);
      y_d = y_i + (x_i >>> IDX);
      z_d = z_i - step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o     <= x_d;
      y_o     <= y_d;
      z_o     <= z_d;
      flags_o <= flags_i;
      ax_o    <= ax_i;
      ay_o    <= ay_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/sdd_root_cell.sv -----
// one quotient bit of the scaled distance search, two registered steps
// depends on sdd_pkg
`default_nettype none

module sdd_root_cell #(
  parameter int BIT = 7
) (
  input  wire logic                        clk_i,
  input  wire logic                        en_a_i,
  input  wire logic                        en_b_i,
  input  wire logic [sdd_pkg::Q_W-1:0]     q_i,
  input  wire logic [sdd_pkg::T_W-1:0]     t_i,
  input  wire logic [15:0]                 m_i,
  input  wire logic [8:0]                  bear_i,
  output logic [sdd_pkg::Q_W-1:0]          q_o,
  output logic [sdd_pkg::T_W-1:0]          t_o,
  output logic [8:0]                       bear_o
);

  logic [sdd_pkg::Q_W-1:0]   trial_d, trial_q, q_q;
  logic [sdd_pkg::MUL_W-1:0] p_d, p_q;
  logic [sdd_pkg::T_W-1:0]   t_q;
  logic [8:0]                bear_q;
  logic [sdd_pkg::SQ_W-1:0]  sq;
  logic                      fits;

  assign trial_d = q_i | (sdd_pkg::Q_W'(1) << BIT);
  assign p_d     = sdd_pkg::MUL_W'(trial_d) * sdd_pkg::MUL_W'(m_i);
  assign sq      = sdd_pkg::SQ_W'(p_q) * sdd_pkg::SQ_W'(p_q);
  assign fits    = sdd_pkg::T_W'(sq) <= t_q;

  always_ff @(posedge clk_i) begin
    if (en_a_i) begin
      trial_q <= trial_d;
      q_q     <= q_i;
      p_q     <= p_d;
      t_q     <= t_i;
      bear_q  <= bear_i;
    end
    if (en_b_i) begin
      q_o    <= fits ? trial_q : q_q;
      t_o    <= t_q;
      bear_o <= bear_q;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/source_direction_and_distance.sv -----
// beats pass difference, operand, rotation, bearing, scale and quotient registers
// throughput: a beat per cycle unless stalled, set by rotation and quotient cells
// a stalled output holds only the stages that are full, bubbles collapse
// reset clears all stage valids and sets max_dist_q to 400
// top level of the source bearing and distance block
// depends on sdd_pkg, sdd_cordic_cell, sdd_root_cell
`default_nettype none

module source_direction_and_distance #(
  parameter int COORD_BITS    = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire sdd_pkg::in_beat_t  in_beat_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output sdd_pkg::out_beat_t      out_beat_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [15:0]        cfg_data_i
);

  localparam int AW  = COORD_BITS;
  localparam int DW  = AW + 1;
  localparam int XW  = AW + sdd_pkg::FRAC_BITS + 3;
  localparam int SW  = 2 * AW + 1;
  localparam int CW  = (SW > sdd_pkg::S_CLAMP_W) ? SW : sdd_pkg::S_CLAMP_W;
  localparam int CS  = CORDIC_STAGES;
  localparam int FS  = CS + 2;
  localparam int MS  = FS + 1;
  localparam int NST = CS + 20;
  localparam int FB  = sdd_pkg::FRAC_BITS;
  localparam int AN  = sdd_pkg::ANG_W;

  // configuration
  logic [15:0] max_dist_q;
  logic [15:0] m_eff;

  assign cfg_ready_o = 1'b1;
  assign m_eff       = (max_dist_q == '0) ? 16'd1 : max_dist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dist_q <= sdd_pkg::DIST_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_dist_q <= cfg_data_i;
    end
  end

  // stage control
  logic [NST-1:0] v_q, v_d, en;

  for (genvar k = 0; k < NST; k++) begin : g_en
    assign en[k] = ~(&v_q[NST-1:k]) | ~out_stall_i;
  end

  assign v_d        = {v_q[NST-2:0], in_valid_i};
  assign in_stall_o = ~en[0];
  assign out_valid_o = v_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= (en & v_d) | (~en & v_q);
    end
  end

  // capture and differences
  logic [23:0]             lx_e, ly_e, sx_e, sy_e;
  logic signed [AW-1:0]    lx, ly, sx, sy;
  logic signed [DW-1:0]    dx_q, dy_q;

  assign lx_e = {8'b0, in_beat_i.listener_x};
  assign ly_e = {8'b0, in_beat_i.listener_y};
  assign sx_e = {8'b0, in_beat_i.source_x};
  assign sy_e = {8'b0, in_beat_i.source_y};
  assign lx   = lx_e[AW-1:0];
  assign ly   = ly_e[AW-1:0];
  assign sx   = sx_e[AW-1:0];
  assign sy   = sy_e[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      dx_q <= DW'(sx) - DW'(lx);
      dy_q <= DW'(sy) - DW'(ly);
    end
  end

  // magnitudes, quadrant and operand choice
  logic [DW-1:0]    adx, ady;
  logic [AW-1:0]    ax_d, ay_d, num_d, den_d;
  sdd_pkg::flags_t  fl_d;
  logic [AW-1:0]    ax_q, ay_q, num_q, den_q;
  sdd_pkg::flags_t  fl_q;

  always_comb begin
    adx  = dx_q[DW-1] ? DW'(-dx_q) : DW'(dx_q);
    ady  = dy_q[DW-1] ? DW'(-dy_q) : DW'(dy_q);
    ax_d = adx[AW-1:0];
    ay_d = ady[AW-1:0];
    fl_d.dx_pos     = !dx_q[DW-1] && (dx_q != '0);
    fl_d.dy_pos     = !dy_q[DW-1] && (dy_q != '0);
    fl_d.dy_zero    = (dy_q == '0);
    fl_d.coincident = (dx_q == '0) && (dy_q == '0);
    num_d = fl_d.dx_pos ? ay_d : ax_d;
    den_d = fl_d.dx_pos ? ax_d : ay_d;
    fl_d.num_zero = (num_d == '0);
    fl_d.num_eq   = (num_d == den_d);
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      ax_q  <= ax_d;
      ay_q  <= ay_d;
      num_q <= num_d;
      den_q <= den_d;
      fl_q  <= fl_d;
    end
  end

  // rotation chain
  logic signed [XW-1:0] cx [CS+1];
  logic signed [XW-1:0] cy [CS+1];
  logic signed [AN-1:0] cz [CS+1];
  sdd_pkg::flags_t      cf [CS+1];
  logic [AW-1:0]        cax [CS+1];
  logic [AW-1:0]        cay [CS+1];

  assign cx[0]  = {3'b0, den_q, {FB{1'b0}}};
  assign cy[0]  = {3'b0, num_q, {FB{1'b0}}};
  assign cz[0]  = '0;
  assign cf[0]  = fl_q;
  assign cax[0] = ax_q;
  assign cay[0] = ay_q;

  for (genvar i = 0; i < CS; i++) begin : g_rot
    sdd_cordic_cell #(
      .XW (XW),
      .AW (AW),
      .IDX(i)
    ) u_cell (
      .clk_i  (clk_i),
      .en_i   (en[i+2]),
      .x_i    (cx[i]),
      .y_i    (cy[i]),
      .z_i    (cz[i]),
      .flags_i(cf[i]),
      .ax_i   (cax[i]),
      .ay_i   (cay[i]),
      .x_o    (cx[i+1]),
      .y_o    (cy[i+1]),
      .z_o    (cz[i+1]),
      .flags_o(cf[i+1]),
      .ax_o   (cax[i+1]),
      .ay_o   (cay[i+1])
    );
  end

  // bearing and squared distance
  logic signed [AN-1:0] zf;
  logic [AN-FB-1:0]     zint;
  logic [8:0]           tdeg, bear_d, bear_f_q;
  sdd_pkg::flags_t      ff;
  logic [SW-1:0]        s_d, s_q;

  assign zf   = cz[CS];
  assign zint = zf[AN-1:FB];
  assign ff   = cf[CS];

  always_comb begin
    if (ff.num_zero || zf[AN-1]) begin
      tdeg = '0;
    end else if (ff.num_eq) begin
      tdeg = sdd_pkg::ANG_HALF;
    end else if (9'(zint) > sdd_pkg::ANG_MAX) begin
      tdeg = sdd_pkg::ANG_MAX;
    end else begin
      tdeg = 9'(zint);
    end
    if (ff.coincident) begin
      bear_d = sdd_pkg::BEAR_UP;
    end else if (ff.dx_pos) begin
      bear_d = ff.dy_pos ? sdd_pkg::BEAR_RIGHT + tdeg : sdd_pkg::BEAR_RIGHT - tdeg;
    end else if (ff.dy_zero) begin
      bear_d = sdd_pkg::BEAR_LEFT;
    end else if (ff.dy_pos) begin
      bear_d = sdd_pkg::BEAR_DOWN + tdeg;
    end else if (tdeg == '0) begin
      bear_d = sdd_pkg::BEAR_UP;
    end else begin
      bear_d = sdd_pkg::BEAR_FULL - tdeg;
    end
    s_d = SW'(cax[CS]) * SW'(cax[CS]) + SW'(cay[CS]) * SW'(cay[CS]);
  end

  always_ff @(posedge clk_i) begin
    if (en[FS]) begin
      bear_f_q <= bear_d;
      s_q      <= s_d;
    end
  end

  // far check and scaled square
  logic [sdd_pkg::S_CLAMP_W-1:0] s_c;
  logic [sdd_pkg::T_W-1:0]       t_q;
  logic                          far_q;
  logic [8:0]                    bear_m_q;

  assign s_c = sdd_pkg::S_CLAMP_W'(s_q);

  always_ff @(posedge clk_i) begin
    if (en[MS]) begin
      far_q    <= CW'(s_q) >= CW'(sdd_pkg::FAR_SQ);
      t_q      <= sdd_pkg::T_W'(s_c) * sdd_pkg::T_W'(sdd_pkg::DIST_SCALE);
      bear_m_q <= bear_f_q;
    end
  end

  // quotient bit cells, msb first
  logic [sdd_pkg::Q_W-1:0] rq [sdd_pkg::Q_W+1];
  logic [sdd_pkg::T_W-1:0] rt [sdd_pkg::Q_W+1];
  logic [8:0]              rb [sdd_pkg::Q_W+1];

  assign rq[0] = far_q ? sdd_pkg::Q_SAT : '0;
  assign rt[0] = t_q;
  assign rb[0] = bear_m_q;

  for (genvar j = 0; j < sdd_pkg::Q_W; j++) begin : g_root
    sdd_root_cell #(
      .BIT(sdd_pkg::Q_W - 1 - j)
    ) u_cell (
      .clk_i (clk_i),
      .en_a_i(en[MS+1+2*j]),
      .en_b_i(en[MS+2+2*j]),
      .q_i   (rq[j]),
      .t_i   (rt[j]),
      .m_i   (m_eff),
      .bear_i(rb[j]),
      .q_o   (rq[j+1]),
      .t_o   (rt[j+1]),
      .bear_o(rb[j+1])
    );
  end

  always_comb begin
    out_beat_o.bearing_deg     = rb[sdd_pkg::Q_W];
    out_beat_o.scaled_distance = (rq[sdd_pkg::Q_W] == '0) ? sdd_pkg::Q_MIN
                                                          : rq[sdd_pkg::Q_W];
  end

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while output free");

  a_bearing_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_beat_o.bearing_deg < sdd_pkg::BEAR_FULL))
    else $error("bearing out of range");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !v_q[NST-2]) |=> !out_valid_o)
    else $error("result beat repeated");

endmodule

`default_nettype wire
